// ===== rtl/b64d_pkg.sv =====
// b64d_pkg: shared types, constants and the character decode function
// for the base64 decoder. No dependencies.
package b64d_pkg;

   // Alphabet bounds and the two special symbols
   localparam logic [7:0] UPPER_FIRST = 8'h41;
   localparam logic [7:0] UPPER_LAST  = 8'h5A;
   localparam logic [7:0] LOWER_FIRST = 8'h61;
   localparam logic [7:0] LOWER_LAST  = 8'h7A;
   localparam logic [7:0] DIGIT_FIRST = 8'h30;
   localparam logic [7:0] DIGIT_LAST  = 8'h39;
   localparam logic [7:0] PLUS_CHAR   = 8'h2B;
   localparam logic [7:0] SLASH_CHAR  = 8'h2F;
   localparam logic [7:0] LOWER_BASE  = 8'd26;
   localparam logic [7:0] DIGIT_BASE  = 8'd52;
   localparam logic [5:0] PLUS_VALUE  = 6'd62;
   localparam logic [5:0] SLASH_VALUE = 6'd63;

   typedef struct packed {
      logic       ok;     // 0: '=' or any non-alphabet byte (stop)
      logic [5:0] value;
   } sextet_type;

   // One queued job: up to three bytes of one input item, oldest in [0]
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;   // 0 only for an empty end-of-message result
      logic            msg_end;
   } b64d_job_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.ok    = 1'b1;
      s.value = '0;
      if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
         s.value = 6'(c - UPPER_FIRST);
      end else if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
         s.value = 6'(c - LOWER_FIRST + LOWER_BASE);
      end else if (c >= DIGIT_FIRST && c <= DIGIT_LAST) begin
         s.value = 6'(c - DIGIT_FIRST + DIGIT_BASE);
      end else if (c == PLUS_CHAR) begin
         s.value = PLUS_VALUE;
      end else if (c == SLASH_CHAR) begin
         s.value = SLASH_VALUE;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage

// ===== rtl/b64d_front.sv =====
// b64d_front: accepts characters, keeps the group state and forms byte jobs.
// Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic [7:0]   req_char_in,
   input  logic         req_message_last,
   input  logic         queue_full,
   output logic         req_full,
   output logic         job_push,
   output b64d_job_type job
);

   logic [17:0] held_sextets_ff, held_sextets_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        stopped_ff, stopped_in;
   logic        accept;
   sextet_type  sx;
   logic [23:0] group;

   assign req_full = queue_full;
   assign accept   = req_push & ~queue_full;
   assign sx       = sextet_of(req_char_in);
   assign group    = {held_sextets_ff, sx.value};

   always_comb begin
      held_sextets_in = held_sextets_ff;
      held_count_in   = held_count_ff;
      stopped_in      = stopped_ff;
      job.bytes       = '0;
      job.count       = 2'd0;
      job.msg_end     = req_message_last;

      if (!stopped_ff) begin
         if (!sx.ok) begin
            stopped_in = 1'b1;
         end else if (held_count_ff == 2'd3) begin
            job.bytes[0]    = group[23:16];
            job.bytes[1]    = group[15:8];
            job.bytes[2]    = group[7:0];
            job.count       = 2'd3;
            held_sextets_in = '0;
            held_count_in   = 2'd0;
         end else begin
            held_sextets_in = {held_sextets_ff[11:0], sx.value};
            held_count_in   = held_count_ff + 2'd1;
         end
      end

      // flush of a partial group; zero padding falls off the low end
      if (req_message_last) begin
         if (held_count_in == 2'd2) begin
            job.bytes[0] = held_sextets_in[11:4];
            job.count    = 2'd1;
         end else if (held_count_in == 2'd3) begin
            job.bytes[0] = held_sextets_in[17:10];
            job.bytes[1] = held_sextets_in[9:2];
            job.count    = 2'd2;
         end
         held_sextets_in = '0;
         held_count_in   = 2'd0;
         stopped_in      = 1'b0;
      end
   end

   // items that give nothing and do not end the message are dropped here
   assign job_push = accept & ((job.count != 2'd0) | req_message_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_sextets_ff <= '0;
         held_count_ff   <= 2'd0;
         stopped_ff      <= 1'b0;
      end else if (accept) begin
         held_sextets_ff <= held_sextets_in;
         held_count_ff   <= held_count_in;
         stopped_ff      <= stopped_in;
      end
   end

endmodule

// ===== rtl/b64d_queue.sv =====
// b64d_queue: short register queue of byte jobs between front and back.
// Depends on b64d_pkg.
module b64d_queue import b64d_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  b64d_job_type push_job,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output b64d_job_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64d_job_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/b64d_back.sv =====
// b64d_back: splits queued jobs into results in the output register, one per cycle
// while results are popped. Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  b64d_job_type head,
   output logic         head_done,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output logic [7:0]   rsp_byte_out,
   output logic         rsp_byte_valid,
   output logic         rsp_run_last,
   output logic         rsp_message_end
);

   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff;
   logic       byte_valid_ff, run_last_ff, msg_end_ff;
   logic       load, run_last;
   logic [7:0] sel_byte;

   assign load     = head_valid & (~out_valid_ff | rsp_pop);
   assign run_last = (head.count == 2'd0) || (idx_ff == head.count - 2'd1);
   assign sel_byte = (head.count == 2'd0) ? 8'd0 : head.bytes[idx_ff];
   assign head_done = load & run_last;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = run_last ? 2'd0 : idx_ff + 2'd1;
      end
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= sel_byte;
         byte_valid_ff <= (head.count != 2'd0);
         run_last_ff   <= run_last;
         msg_end_ff    <= head.msg_end & run_last;
      end
   end

   assign rsp_empty       = ~out_valid_ff;
   assign rsp_byte_out    = byte_ff;
   assign rsp_byte_valid  = byte_valid_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_message_end = msg_end_ff;

endmodule

// ===== rtl/base64_decoder_top.sv =====
// base64_decoder_top: streaming base64 decoder, one character per item.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//   channel   ports                                       direction  per item
//   req       req_push/req_full, req_char_in,             in         one character
//             req_message_last
//   rsp       rsp_pop/rsp_empty, rsp_byte_out,            out        one byte or an
//             rsp_byte_valid, rsp_run_last,                          empty end mark
//             rsp_message_end
//
// One character is taken per clock while the job queue has room; the decode
// and the group state update happen in the cycle of acceptance.
// Results leave at one per clock from the output register while rsp_pop takes
// them, so a full group (three bytes) holds the back end for three results;
// the job queue absorbs that and input stalls (req_full) only when QUEUE_DEPTH
// jobs are waiting. A character's job is written to the queue when it is
// accepted; the output register loads its first result once free or popped.
// Synchronous active-high reset clears the group state, queue and output valid.
module base64_decoder_top import b64d_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_in,
   input  logic       req_message_last,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_message_end
);

   logic         queue_full;
   logic         queue_empty;
   logic         job_push;
   logic         head_done;
   b64d_job_type job;
   b64d_job_type head;

   // Front: character decode, held sextets, stop flag, flush on the last item
   b64d_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_char_in      (req_char_in),
      .req_message_last (req_message_last),
      .queue_full       (queue_full),
      .req_full         (req_full),
      .job_push         (job_push),
      .job              (job)
   );

   // Job queue: decouples a three-byte group from the next character
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (head_done),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head)
   );

   // Back: one result per cycle while results are popped, output register acts as the skid stage
   b64d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (~queue_empty),
      .head            (head),
      .head_done       (head_done),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end)
   );

endmodule

// ===== rtl/b64d_checker.sv =====
// b64d_checker: port-level checks for base64_decoder_top, attached by bind.
// Depends only on the top level's ports.
module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_pop,
   input logic       rsp_empty,
   input logic [7:0] rsp_byte_out,
   input logic       rsp_byte_valid,
   input logic       rsp_run_last,
   input logic       rsp_message_end
);

   // a waiting result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_byte_out) &&
         $stable(rsp_byte_valid) && $stable(rsp_run_last) && $stable(rsp_message_end)))
      else $error("waiting result changed before pop");

   // message end only on the last result of an item
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_message_end) |-> rsp_run_last)
      else $error("message_end without run_last");

   // an empty result is only the end-of-message mark, with a zero byte
   a_empty_res: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_byte_valid) |->
         (rsp_byte_out == 8'd0 && rsp_run_last && rsp_message_end))
      else $error("malformed empty result");

   // nothing waits on the cycle after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result present after reset");

endmodule

bind base64_decoder_top b64d_checker u_b64d_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_pop         (rsp_pop),
   .rsp_empty       (rsp_empty),
   .rsp_byte_out    (rsp_byte_out),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_run_last    (rsp_run_last),
   .rsp_message_end (rsp_message_end)
);
